// ===== hw/rtl/htw_pkg.sv =====
// Package for the Huffman tree-walk decoder: node record layout, field widths,
// command and CSR codes. No dependencies; imported by htw_node_store, the decoder unit and the bench.

package htw_pkg;

   // Field widths fixed by the stream format
   localparam int IDX_W       = 9;
   localparam int SYM_W       = 8;
   localparam int BYTE_W      = 8;
   localparam int TOTAL_W     = 32;
   localparam int BIT_CNT_W   = $clog2(BYTE_W + 1);

   // Child value that marks a leaf when both children carry it
   localparam logic [IDX_W-1:0] LEAF_MARK = IDX_W'(254);

   // Default node memory depth
   localparam int MAX_NODES_DEFAULT = 512;

   // Request kinds carried on tuser
   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_DATA = 1'b1;

   // CSR indexes
   localparam int  CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_SYMBOL_TOTAL = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_ROOT_INDEX   = 1'b1;

   // One tree node as stored in memory
   typedef struct packed {
      logic [SYM_W-1:0] symbol;
      logic [IDX_W-1:0] left;
      logic [IDX_W-1:0] right;
   } node_type;

   localparam int NODE_W = $bits(node_type);

   // Node write request into the node store
   typedef struct packed {
      logic             en;
      logic [IDX_W-1:0] index;
      node_type         node;
   } node_wr_type;

   // Node as seen by the walker, with the leaf decode
   typedef struct packed {
      node_type node;
      logic     leaf;
   } node_view_type;

endpackage

// ===== hw/rtl/htw_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.

module htw_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== hw/rtl/htw_node_store.sv =====
// Node memory of the tree-walk decoder: range check on the 9-bit node index,
// zero substitution for indexes beyond the memory, and leaf decode.
// Depends on htw_pkg and htw_ram.

module htw_node_store import htw_pkg::*; #(
   parameter int MAX_NODES = MAX_NODES_DEFAULT
) (
   input  logic             clock,
   input  node_wr_type      wr,
   input  logic [IDX_W-1:0] rd_index,
   output node_view_type    rd_view
);

   localparam int AW = $clog2(MAX_NODES);

   logic [31:0]   wr_idx32;
   logic [31:0]   rd_idx32;
   logic          wr_ok;
   logic          rd_ok;
   logic          rd_ok_ff;
   logic [NODE_W-1:0] ram_q;
   node_type      node;

   // Map the node index onto the memory address, flag indexes past the end
   assign wr_idx32 = 32'(wr.index);
   assign rd_idx32 = 32'(rd_index);
   assign wr_ok    = (wr_idx32 < 32'(MAX_NODES));
   assign rd_ok    = (rd_idx32 < 32'(MAX_NODES));

   htw_ram #(
      .WIDTH (NODE_W),
      .DEPTH (MAX_NODES)
   ) u_ram (
      .clock (clock),
      .we    (wr.en & wr_ok),
      .waddr (wr_idx32[AW-1:0]),
      .wdata (wr.node),
      .raddr (rd_idx32[AW-1:0]),
      .rdata (ram_q)
   );

   // Track the range check alongside the registered read
   always_ff @(posedge clock) begin
      rd_ok_ff <= rd_ok;
   end

   // Out-of-range nodes read as all zero
   always_comb begin
      node         = rd_ok_ff ? node_type'(ram_q) : '0;
      rd_view.node = node;
      rd_view.leaf = (node.left == LEAF_MARK) && (node.right == LEAF_MARK);
   end

endmodule

// ===== hw/rtl/huffman_tree_walk_decoder_unit.sv =====
// Huffman tree-walk decoder: a sequencer that steps the node memory read port once per bit and per root refetch.
// Load transaction: writes one node. Data transaction: accept and fetch the current node, follow
// each bit, refetch the root after each decoded symbol, see the end of the byte and close it;
// the walk stops early once the symbol total is reached. Output stalls hold the walk.
// The rate is set by the single registered read of the node memory; requests are taken only while idle.
// Synchronous active-high reset clears the walk, count and CSRs; node memory is not cleared.

module huffman_tree_walk_decoder_unit import htw_pkg::*; #(
   parameter int MAX_NODES = MAX_NODES_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   // Request channel
   input  logic                 req_tvalid,
   output logic                 req_tready,
   // tdata: node_index[8:0], node_symbol[16:9], left_child[25:17],
   //        right_child[34:26], data_byte[42:35], zero fill [47:43]
   input  logic [47:0]          req_tdata,
   // tuser: command
   input  logic                 req_tuser,
   // Response channel
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   // tdata: symbol[7:0]
   output logic [SYM_W-1:0]     rsp_tdata,
   // tlast: last_in_run
   output logic                 rsp_tlast,
   // tuser: stream_done
   output logic                 rsp_tuser,
   // CSR write port
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [TOTAL_W-1:0]   csr_wdata
);

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_WALK  = 3'b010,
      ST_FLUSH = 3'b100
   } walk_state_type;

   walk_state_type       state_ff, state_in;
   logic [IDX_W-1:0]     current_ff, current_in;
   logic [TOTAL_W-1:0]   count_ff, count_in;
   logic [TOTAL_W-1:0]   total_ff, total_in;
   logic [IDX_W-1:0]     root_ff, root_in;
   logic [BYTE_W-1:0]    byte_ff, byte_in;
   logic [BIT_CNT_W-1:0] bits_left_ff, bits_left_in;
   logic                 arrived_ff, arrived_in;
   logic                 pend_valid_ff, pend_valid_in;
   logic [SYM_W-1:0]     pend_sym_ff, pend_sym_in;
   logic                 pend_done_ff, pend_done_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [SYM_W-1:0]     rsp_sym_ff, rsp_sym_in;
   logic                 rsp_last_ff, rsp_last_in;
   logic                 rsp_done_ff, rsp_done_in;

   logic [IDX_W-1:0]     rd_index;
   node_wr_type          wr;
   node_view_type        view;
   logic                 slot_free;
   logic [TOTAL_W-1:0]   count_inc;
   logic                 done_next;
   logic                 stop;
   logic [IDX_W-1:0]     child;

   // Request field views
   logic [IDX_W-1:0]     f_node_index;
   logic [SYM_W-1:0]     f_node_symbol;
   logic [IDX_W-1:0]     f_left;
   logic [IDX_W-1:0]     f_right;
   logic [BYTE_W-1:0]    f_data_byte;

   assign f_node_index  = req_tdata[8:0];
   assign f_node_symbol = req_tdata[16:9];
   assign f_left        = req_tdata[25:17];
   assign f_right       = req_tdata[34:26];
   assign f_data_byte   = req_tdata[42:35];

   htw_node_store #(
      .MAX_NODES (MAX_NODES)
   ) u_store (
      .clock    (clock),
      .wr       (wr),
      .rd_index (rd_index),
      .rd_view  (view)
   );

   assign slot_free = !rsp_valid_ff || rsp_tready;
   assign count_inc = count_ff + TOTAL_W'(1);
   assign done_next = (count_inc >= total_ff);
   assign stop      = (bits_left_ff == '0) || (count_ff >= total_ff);
   assign child     = byte_ff[BYTE_W-1] ? view.node.right : view.node.left;

   // Sequencer: one node read per step
   always_comb begin
      state_in      = state_ff;
      current_in    = current_ff;
      count_in      = count_ff;
      total_in      = total_ff;
      root_in       = root_ff;
      byte_in       = byte_ff;
      bits_left_in  = bits_left_ff;
      arrived_in    = arrived_ff;
      pend_valid_in = pend_valid_ff;
      pend_sym_in   = pend_sym_ff;
      pend_done_in  = pend_done_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_sym_in    = rsp_sym_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_done_in   = rsp_done_ff;
      rd_index      = current_ff;
      wr            = '0;

      // Drop the output transaction once taken
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               if (req_tuser == CMD_LOAD) begin
                  wr.en          = 1'b1;
                  wr.index       = f_node_index;
                  wr.node.symbol = f_node_symbol;
                  wr.node.left   = f_left;
                  wr.node.right  = f_right;
               end else begin
                  byte_in      = f_data_byte;
                  bits_left_in = BIT_CNT_W'(BYTE_W);
                  arrived_in   = 1'b0;
                  rd_index     = current_ff;
                  state_in     = ST_WALK;
               end
            end
         end
         ST_WALK: begin
            if (arrived_ff && view.leaf) begin
               // Leaf reached: hand the held symbol on, hold the new one, refetch root
               if (!pend_valid_ff || slot_free) begin
                  if (pend_valid_ff) begin
                     rsp_valid_in = 1'b1;
                     rsp_sym_in   = pend_sym_ff;
                     rsp_last_in  = 1'b0;
                     rsp_done_in  = pend_done_ff;
                  end
                  pend_valid_in = 1'b1;
                  pend_sym_in   = view.node.symbol;
                  pend_done_in  = done_next;
                  count_in      = count_inc;
                  current_in    = root_ff;
                  rd_index      = root_ff;
                  arrived_in    = 1'b0;
               end else begin
                  rd_index = current_ff;
               end
            end else if (stop) begin
               state_in = ST_FLUSH;
            end else begin
               // Follow one bit, most significant first
               current_in   = child;
               rd_index     = child;
               arrived_in   = 1'b1;
               bits_left_in = bits_left_ff - BIT_CNT_W'(1);
               byte_in      = {byte_ff[BYTE_W-2:0], 1'b0};
            end
         end
         ST_FLUSH: begin
            // Close the byte: the held symbol is its last
            if (!pend_valid_ff) begin
               state_in = ST_IDLE;
            end else if (slot_free) begin
               rsp_valid_in  = 1'b1;
               rsp_sym_in    = pend_sym_ff;
               rsp_last_in   = 1'b1;
               rsp_done_in   = pend_done_ff;
               pend_valid_in = 1'b0;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // CSR writes; the host must issue them only while no transaction is in flight; the block does not enforce it
      if (csr_we) begin
         unique case (csr_index)
            CSR_SYMBOL_TOTAL: total_in = csr_wdata;
            CSR_ROOT_INDEX: begin
               root_in    = csr_wdata[IDX_W-1:0];
               current_in = csr_wdata[IDX_W-1:0];
               count_in   = '0;
            end
            default: begin
               total_in = total_ff;
            end
         endcase
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         current_ff    <= '0;
         count_ff      <= '0;
         total_ff      <= '0;
         root_ff       <= '0;
         bits_left_ff  <= '0;
         arrived_ff    <= 1'b0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         current_ff    <= current_in;
         count_ff      <= count_in;
         total_ff      <= total_in;
         root_ff       <= root_in;
         bits_left_ff  <= bits_left_in;
         arrived_ff    <= arrived_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Payload
   always_ff @(posedge clock) begin
      byte_ff      <= byte_in;
      pend_sym_ff  <= pend_sym_in;
      pend_done_ff <= pend_done_in;
      rsp_sym_ff   <= rsp_sym_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_done_ff  <= rsp_done_in;
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_sym_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_done_ff;

`ifndef NO_ASSERTIONS
   // No symbol is held back while a new transaction can be accepted
   a_idle_no_pend: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !pend_valid_ff)
      else $error("held symbol left over in idle");

   // The symbol that completes the stream always closes its byte
   a_done_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> rsp_tlast)
      else $error("stream_done without tlast");

   // The symbol count moves only during a walk or by a root write
   a_count_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE && !csr_we) |=> (count_ff == $past(count_ff)))
      else $error("symbol count changed while idle");
`endif

endmodule

// ===== dv/tb_top.sv =====
// Testbench for huffman_tree_walk_decoder_unit: loads code trees, streams coded bytes and
// checks every decoded symbol against a tree-walk predictor kept in the bench.
// Depends on htw_pkg and the decoder RTL only.
`timescale 1ns / 100ps

module tb_top;
   import htw_pkg::*;

   localparam int          NODE_COUNT    = MAX_NODES_DEFAULT;
   localparam int          DRAIN_CYCLES  = 100;
   localparam int          LONG_HOLD     = 400;
   localparam int          ITEM_TARGET   = 230;
   localparam int unsigned CYCLE_LIMIT   = 300_000;

   // Request tdata layout, node_index in the lowest bits
   typedef struct packed {
      logic [4:0]        fill;
      logic [BYTE_W-1:0] data_byte;
      logic [IDX_W-1:0]  right_child;
      logic [IDX_W-1:0]  left_child;
      logic [SYM_W-1:0]  node_symbol;
      logic [IDX_W-1:0]  node_index;
   } request_fields_type;

   typedef struct packed {
      logic [SYM_W-1:0] symbol;
      logic             last_in_run;
      logic             stream_done;
   } symbol_result_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   request_fields_type   req_tdata = '0;
   logic                 req_tuser = CMD_LOAD;
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [SYM_W-1:0]     rsp_tdata;
   logic                 rsp_tlast;
   logic                 rsp_tuser;
   logic                 csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = CSR_SYMBOL_TOTAL;
   logic [TOTAL_W-1:0]   csr_wdata = '0;

   // Predictor state: node store, walk position, emitted count and CSR copies
   logic [SYM_W-1:0]     node_sym   [NODE_COUNT];
   logic [IDX_W-1:0]     node_left  [NODE_COUNT];
   logic [IDX_W-1:0]     node_right [NODE_COUNT];
   logic [IDX_W-1:0]     walk_node = '0;
   logic [TOTAL_W-1:0]   emitted_count = '0;
   logic [TOTAL_W-1:0]   cfg_total = '0;
   logic [IDX_W-1:0]     cfg_root = '0;
   symbol_result_type    expected_symbols [$];

   // Stimulus bookkeeping: nodes already loaded, slots taken by the tree being built
   bit                   node_written [NODE_COUNT];
   logic [IDX_W-1:0]     written_nodes [$];
   bit                   tree_slot_used [NODE_COUNT];

   int unsigned          req_max_gap = 10;
   int unsigned          rsp_max_stall = 10;
   bit                   long_hold_pending = 1'b0;
   int unsigned          items_sent = 0;
   int unsigned          mismatch_count = 0;
   int unsigned          cycle_count = 0;

   huffman_tree_walk_decoder_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("** huffman_tree_walk_decoder_unit: FAILED **");
         $finish;
      end
   end

   function automatic void report_mismatch(input string msg);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("[%0t] %s", $time, msg);
   endfunction

   // Walk the tree for one coded byte, MSB first, and queue the symbols it emits
   function automatic void predict_byte(input logic [BYTE_W-1:0] coded);
      symbol_result_type run [$];
      logic [IDX_W-1:0]  next_node;
      for (int b = BYTE_W - 1; b >= 0; b--) begin
         if (emitted_count >= cfg_total)
            break;
         next_node = coded[b] ? node_right[walk_node] : node_left[walk_node];
         walk_node = next_node;
         if (node_left[next_node] == LEAF_MARK && node_right[next_node] == LEAF_MARK) begin
            emitted_count++;
            run.push_back('{node_sym[next_node], 1'b0, emitted_count >= cfg_total});
            walk_node = cfg_root;
         end
      end
      if (run.size() > 0)
         run[run.size() - 1].last_in_run = 1'b1;
      foreach (run[i])
         expected_symbols.push_back(run[i]);
   endfunction

   // Offer one transaction after a random gap; update the predictor once accepted
   task automatic send_item(input logic cmd, input request_fields_type fields);
      int unsigned gap;
      gap = $urandom_range(0, req_max_gap);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= fields;
      do @(posedge clock); while (!req_tready);
      items_sent++;
      if (cmd == CMD_LOAD) begin
         node_sym[fields.node_index]   = fields.node_symbol;
         node_left[fields.node_index]  = fields.left_child;
         node_right[fields.node_index] = fields.right_child;
      end else begin
         predict_byte(fields.data_byte);
      end
   endtask

   task automatic send_load(input logic [IDX_W-1:0] idx, input logic [SYM_W-1:0] sym,
                            input logic [IDX_W-1:0] lft, input logic [IDX_W-1:0] rgt);
      request_fields_type f;
      f = '0;
      f.node_index  = idx;
      f.node_symbol = sym;
      f.left_child  = lft;
      f.right_child = rgt;
      f.data_byte   = BYTE_W'($urandom);
      send_item(CMD_LOAD, f);
      if (!node_written[idx]) begin
         node_written[idx] = 1'b1;
         written_nodes.push_back(idx);
      end
   endtask

   // Node fields of a data transaction are don't-care; randomize them
   task automatic send_byte(input logic [BYTE_W-1:0] coded);
      request_fields_type f;
      f = '0;
      f.node_index  = IDX_W'($urandom);
      f.node_symbol = SYM_W'($urandom);
      f.left_child  = IDX_W'($urandom);
      f.right_child = IDX_W'($urandom);
      f.data_byte   = coded;
      send_item(CMD_DATA, f);
   endtask

   // Drop valid, drain all expected symbols, then let in-flight bytes finish
   task automatic wait_for_idle();
      req_tvalid <= 1'b0;
      while (expected_symbols.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [TOTAL_W-1:0] value);
      wait_for_idle();
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_SYMBOL_TOTAL) begin
         cfg_total = value;
      end else begin
         cfg_root      = value[IDX_W-1:0];
         walk_node     = cfg_root;
         emitted_count = '0;
      end
   endtask

   // Upper data bits above the index are don't-care
   task automatic set_root(input logic [IDX_W-1:0] root);
      logic [TOTAL_W-1:0] value;
      value = $urandom;
      value[IDX_W-1:0] = root;
      write_csr(CSR_ROOT_INDEX, value);
   endtask

   function automatic logic [IDX_W-1:0] pick_fresh_slot();
      logic [IDX_W-1:0] slot;
      do slot = IDX_W'($urandom_range(0, NODE_COUNT - 1)); while (tree_slot_used[slot]);
      tree_slot_used[slot] = 1'b1;
      return slot;
   endfunction

   // Fixed tree: codes 0, 10, 110; 111 loops back to the root without a symbol
   task automatic test_fixed_code_tree();
      send_load(9'd511, 8'hFF, 9'd0, 9'd254);   // only the right child is 254
      send_load(9'd0,   8'h00, LEAF_MARK, LEAF_MARK);
      send_load(9'd254, 8'h5A, 9'd1, 9'd510);
      send_load(9'd1,   8'hFF, LEAF_MARK, LEAF_MARK);
      send_load(9'd510, 8'h3C, 9'd2, 9'd511);
      send_load(9'd2,   8'hA5, LEAF_MARK, LEAF_MARK);
      write_csr(CSR_SYMBOL_TOTAL, '1);
      set_root(9'd511);
      send_byte(8'h00);                         // eight symbols from one byte
      send_byte(8'hFF);                         // no leaf, walk parked mid-tree
      send_load(9'd2, 8'hC3, LEAF_MARK, LEAF_MARK);   // rewrite a leaf under the walk
      send_byte(8'h00);
      send_byte(8'h55);
      send_byte(8'hAA);
      send_byte(8'h6D);
      send_byte(8'h01);
      send_byte(8'h80);
   endtask

   // Stop at the symbol total, ignore later bytes, resume when the total grows
   task automatic test_symbol_total_limit();
      set_root(9'd511);
      write_csr(CSR_SYMBOL_TOTAL, 32'd5);
      send_byte(8'h00);
      send_byte(8'h00);
      write_csr(CSR_SYMBOL_TOTAL, 32'd7);
      send_byte(8'hB6);
      write_csr(CSR_SYMBOL_TOTAL, 32'd0);
      set_root(9'd511);
      send_byte(8'hFF);
      send_byte(8'h00);
      write_csr(CSR_SYMBOL_TOTAL, 32'd1);
      send_byte(8'h40);
      send_byte(8'h00);
      // Restart the walk while it is parked mid-tree
      write_csr(CSR_SYMBOL_TOTAL, '1);
      send_byte(8'hFF);
      set_root(9'd511);
      send_byte(8'h80);
   endtask

   // One-bit codes give eight symbols per byte; hold the output to fill the block
   task automatic test_output_backpressure();
      req_max_gap   = 0;
      rsp_max_stall = 2;
      send_load(9'd511, 8'h11, LEAF_MARK, LEAF_MARK);
      send_load(9'd254, 8'h77, LEAF_MARK, LEAF_MARK);
      send_load(9'd0,   8'hC0, 9'd511, 9'd254);
      set_root(9'd0);
      write_csr(CSR_SYMBOL_TOTAL, '1);
      long_hold_pending = 1'b1;
      repeat (30) send_byte(BYTE_W'($urandom));
      req_max_gap   = 10;
      rsp_max_stall = 10;
   endtask

   // Random prefix trees, random totals and idle mixes, with stray node rewrites
   task automatic test_random_code_trees();
      logic [IDX_W-1:0]   pend_node [$];
      int unsigned        pend_depth [$];
      logic [IDX_W-1:0]   idx;
      logic [IDX_W-1:0]   lft;
      logic [IDX_W-1:0]   rgt;
      logic [IDX_W-1:0]   root;
      logic [TOTAL_W-1:0] total;
      int unsigned        depth;
      int unsigned        depth_cap;
      while (items_sent < ITEM_TARGET) begin
         case ($urandom_range(0, 2))
            0: req_max_gap = 0;
            1: req_max_gap = 3;
            default: req_max_gap = 10;
         endcase
         case ($urandom_range(0, 2))
            0: rsp_max_stall = 0;
            1: rsp_max_stall = 3;
            default: rsp_max_stall = 10;
         endcase

         // Build the tree breadth first; the root is always internal
         depth_cap = $urandom_range(1, 4);
         tree_slot_used = '{default: 1'b0};
         root = pick_fresh_slot();
         pend_node.push_back(root);
         pend_depth.push_back(0);
         while (pend_node.size() > 0) begin
            idx   = pend_node.pop_front();
            depth = pend_depth.pop_front();
            if (depth > 0 && (depth >= depth_cap || $urandom_range(0, 99) < 40)) begin
               send_load(idx, SYM_W'($urandom), LEAF_MARK, LEAF_MARK);
            end else begin
               lft = pick_fresh_slot();
               rgt = pick_fresh_slot();
               send_load(idx, SYM_W'($urandom), lft, rgt);
               pend_node.push_back(lft);
               pend_node.push_back(rgt);
               pend_depth.push_back(depth + 1);
               pend_depth.push_back(depth + 1);
            end
         end

         case ($urandom_range(0, 4))
            0: total = $urandom_range(1, 40);
            1: total = '1;
            default: total = $urandom;
         endcase
         write_csr(CSR_SYMBOL_TOTAL, total);
         set_root(root);

         // Mostly coded bytes; rewrite random nodes now and then, never the root
         repeat ($urandom_range(12, 24)) begin
            if ($urandom_range(0, 99) < 15) begin
               idx = IDX_W'($urandom_range(0, NODE_COUNT - 1));
               if (idx != cfg_root) begin
                  if ($urandom_range(0, 3) == 0)
                     send_load(idx, SYM_W'($urandom), LEAF_MARK, LEAF_MARK);
                  else
                     send_load(idx, SYM_W'($urandom),
                               written_nodes[$urandom_range(0, written_nodes.size() - 1)],
                               written_nodes[$urandom_range(0, written_nodes.size() - 1)]);
               end
            end else begin
               send_byte(BYTE_W'($urandom));
            end
         end
      end
   endtask

   // Drive rsp_tready: random stall per symbol, one long hold on request
   initial begin : symbol_sink
      int unsigned stall;
      while (reset) @(posedge clock);
      forever begin
         stall = $urandom_range(0, rsp_max_stall);
         if (long_hold_pending) begin
            stall = LONG_HOLD;
            long_hold_pending = 1'b0;
         end
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!(rsp_tvalid && rsp_tready));
      end
   end

   // Compare each symbol transaction with the oldest expectation
   always @(posedge clock) begin : symbol_checker
      symbol_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_symbols.size() == 0) begin
            report_mismatch($sformatf("unexpected symbol %02h last %0b done %0b",
                                      rsp_tdata, rsp_tlast, rsp_tuser));
         end else begin
            want = expected_symbols.pop_front();
            if (rsp_tdata !== want.symbol || rsp_tlast !== want.last_in_run ||
                rsp_tuser !== want.stream_done)
               report_mismatch($sformatf(
                  "symbol mismatch: expected %02h last %0b done %0b, got %02h last %0b done %0b",
                  want.symbol, want.last_in_run, want.stream_done,
                  rsp_tdata, rsp_tlast, rsp_tuser));
         end
      end
   end

   initial begin : stimulus
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_fixed_code_tree();
      test_symbol_total_limit();
      test_output_backpressure();
      test_random_code_trees();
      wait_for_idle();
      if (mismatch_count == 0)
         $display("** huffman_tree_walk_decoder_unit: PASSED **");
      else
         $display("** huffman_tree_walk_decoder_unit: FAILED **");
      $finish;
   end

endmodule

// ===== sim.f =====
hw/rtl/htw_pkg.sv
hw/rtl/htw_ram.sv
hw/rtl/htw_node_store.sv
hw/rtl/huffman_tree_walk_decoder_unit.sv
dv/tb_top.sv
